[rtl/tsr_pkg.sv]
`default_nettype none

package tsr_pkg;

    localparam int TABLE_SLOTS  = 16;
    localparam int SCRATCH_REGS = 7;
    localparam int SLOT_W       = $clog2(TABLE_SLOTS);
    localparam int REG_W        = (SCRATCH_REGS > 1) ? $clog2(SCRATCH_REGS) : 1;
    localparam int KEY_W        = 16;
    localparam int OUT_REG_W    = 3;
    localparam int STATUS_W     = 3;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_USED  = 2'd1,
        MARK_TOMB  = 2'd2
    } mark_t;

    typedef enum logic {
        CMD_MAP     = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 3'd0,
        ST_ALLOC    = 3'd1,
        ST_RELEASED = 3'd2,
        ST_REL_MISS = 3'd3,
        ST_NO_REG   = 3'd4,
        ST_FULL     = 3'd5
    } status_t;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_PROBE = 1'b1
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch item, start at home slot
        logic step;     // advance probe to next slot
        logic finish;   // resolve item on current slot, write result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;      // current slot holds the key
        logic empty;    // current slot is empty
        logic last;     // current slot is the last one the probe may visit
        logic out_free; // result register can take a new result
    } dp_stat_t;

    // 32-bit xorshift (13, 17, 5), reduced to a slot index
    function automatic logic [SLOT_W-1:0] hash_slot(input logic [KEY_W-1:0] key);
        logic [31:0] x;
        x = {{(32-KEY_W){1'b0}}, key};
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/temp_to_scratch_register_map.sv]
// Each item is resolved by the linear probe, one table slot examined per
// cycle, from the home slot until a hit, an empty slot or the last slot.
// A new item is accepted only after the previous one has been resolved.
// A result waiting in the output register stalls only the final probe cycle.
// Reset (aresetn low, synchronous): all slots empty, all scratch registers
// free, no result pending.
`default_nettype none

module temp_to_scratch_register_map (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] temp_key
    input  wire logic        s_tuser,   // [0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [2:0] scratch_reg, rest zero
    output logic [2:0]       m_tuser    // [2:0] status
);
    import tsr_pkg::*;

    dp_cmd_t                 cmd;
    dp_stat_t                stat;
    logic [OUT_REG_W-1:0]    scratch;

    tsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tsr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_cmd     (s_tuser),
        .s_key     (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_scratch (scratch),
        .m_status  (m_tuser)
    );

    assign m_tdata = {5'b0, scratch};

endmodule

`default_nettype wire

[rtl/tsr_ctrl.sv]
`default_nettype none

module tsr_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire tsr_pkg::dp_stat_t stat,
    output tsr_pkg::dp_cmd_t       cmd
);
    import tsr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        done       = stat.hit || stat.empty || stat.last;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                if (done) begin
                    // hold on this slot until the result register frees up
                    if (stat.out_free) begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/tsr_datapath.sv]
`default_nettype none

module tsr_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_cmd,
    input  wire logic [tsr_pkg::KEY_W-1:0]       s_key,
    input  wire tsr_pkg::dp_cmd_t                cmd,
    output tsr_pkg::dp_stat_t                    stat,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [tsr_pkg::OUT_REG_W-1:0]        m_scratch,
    output logic [tsr_pkg::STATUS_W-1:0]         m_status
);
    import tsr_pkg::*;

    // table storage; key and register fields are only read in used slots
    logic [KEY_W-1:0]  slot_key_reg  [TABLE_SLOTS];
    logic [REG_W-1:0]  slot_sreg_reg [TABLE_SLOTS];
    mark_t             slot_mark_reg [TABLE_SLOTS];
    logic [SCRATCH_REGS-1:0] busy_reg;

    logic              cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] cnt_reg;
    logic              tomb_valid_reg;
    logic [SLOT_W-1:0] tomb_idx_reg;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [REG_W-1:0]  out_sreg_reg;
    status_t           out_status_reg;

    mark_t             cur_mark;
    logic [REG_W-1:0]  cur_sreg;
    logic              is_tomb;
    logic              ins_ok;
    logic [SLOT_W-1:0] ins_idx;
    logic              free_found;
    logic [REG_W-1:0]  free_idx;

    always_comb begin
        cur_mark      = slot_mark_reg[idx_reg];
        cur_sreg      = slot_sreg_reg[idx_reg];
        is_tomb       = (cur_mark == MARK_TOMB);
        stat.hit      = (cur_mark == MARK_USED) && (slot_key_reg[idx_reg] == key_reg);
        stat.empty    = (cur_mark == MARK_EMPTY);
        stat.last     = (cnt_reg == SLOT_W'(TABLE_SLOTS - 1));
        stat.out_free = !m_valid_reg || m_tready;
        // first tombstone passed wins, else the slot under the probe
        ins_ok        = tomb_valid_reg || stat.empty || is_tomb;
        ins_idx       = tomb_valid_reg ? tomb_idx_reg : idx_reg;
    end

    // lowest free scratch register
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int r = SCRATCH_REGS - 1; r >= 0; r--) begin
            if (!busy_reg[r]) begin
                free_found = 1'b1;
                free_idx   = REG_W'(r);
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                slot_mark_reg[i] <= MARK_EMPTY;
            end
            busy_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cmd.finish) begin
                if (cmd_reg == CMD_RELEASE) begin
                    if (stat.hit) begin
                        slot_mark_reg[idx_reg] <= MARK_TOMB;
                        busy_reg[cur_sreg]     <= 1'b0;
                    end
                end else if (!stat.hit && free_found && ins_ok) begin
                    slot_mark_reg[ins_idx] <= MARK_USED;
                    busy_reg[free_idx]     <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg        <= s_cmd;
            key_reg        <= s_key;
            idx_reg        <= hash_slot(s_key);
            cnt_reg        <= '0;
            tomb_valid_reg <= 1'b0;
        end else if (cmd.step) begin
            idx_reg <= idx_reg + SLOT_W'(1);
            cnt_reg <= cnt_reg + SLOT_W'(1);
            if (is_tomb && !tomb_valid_reg) begin
                tomb_valid_reg <= 1'b1;
                tomb_idx_reg   <= idx_reg;
            end
        end
        if (cmd.finish) begin
            if (cmd_reg == CMD_RELEASE) begin
                if (stat.hit) begin
                    out_sreg_reg   <= cur_sreg;
                    out_status_reg <= ST_RELEASED;
                end else begin
                    out_sreg_reg   <= '0;
                    out_status_reg <= ST_REL_MISS;
                end
            end else if (stat.hit) begin
                out_sreg_reg   <= cur_sreg;
                out_status_reg <= ST_HIT;
            end else if (!free_found) begin
                out_sreg_reg   <= '0;
                out_status_reg <= ST_NO_REG;
            end else if (!ins_ok) begin
                out_sreg_reg   <= '0;
                out_status_reg <= ST_FULL;
            end else begin
                slot_key_reg[ins_idx]  <= key_reg;
                slot_sreg_reg[ins_idx] <= free_idx;
                out_sreg_reg           <= free_idx;
                out_status_reg         <= ST_ALLOC;
            end
        end
    end

    assign m_tvalid  = m_valid_reg;
    assign m_scratch = OUT_REG_W'(out_sreg_reg);
    assign m_status  = out_status_reg;

endmodule

`default_nettype wire
